// ===== rtl/core/mbet_pkg.sv =====
// Shared constants and types for the Modbus reply tracker with encoder unwrap.
package mbet_pkg;

	localparam int unsigned FrameLen   = 7;
	localparam int unsigned HeaderLen  = 5;

	localparam logic [7:0] FuncRead    = 8'h03;
	localparam logic [7:0] DataBytes   = 8'h02;

	localparam logic [2:0] CountLast   = 3'd6;
	localparam logic [2:0] CountFull   = 3'd7;
	localparam logic [2:0] CountHdrEnd = 3'd5;

	localparam logic [7:0] RegStation  = 8'd0;
	localparam logic [7:0] RegLowZone  = 8'd1;
	localparam logic [7:0] RegHighZone = 8'd2;
	localparam logic [7:0] RegCpt      = 8'd3;

	localparam logic [7:0]  StationReset  = 8'd1;
	localparam logic [15:0] LowZoneReset  = 16'd1024;
	localparam logic [15:0] HighZoneReset = 16'd3072;
	localparam logic [15:0] CptReset      = 16'd4096;

	localparam int unsigned OutBits  = 104;

	typedef struct packed {
		logic [15:0] low_zone_limit;
		logic [15:0] high_zone_limit;
		logic [15:0] counts_per_turn;
	} zone_cfg_t;

	typedef struct packed {
		logic [15:0] position_delta;
		logic [15:0] turn_count;
	} unwrap_t;

endpackage

// ===== rtl/core/mbet_unwrap.sv =====
// Wrap-corrected position delta and turn counter update.
module mbet_unwrap (
	input  logic [15:0]        new_pos,
	input  logic [15:0]        old_pos,
	input  logic [15:0]        turns,
	input  mbet_pkg::zone_cfg_t zone,
	output mbet_pkg::unwrap_t  result
);

	logic        wrap_up;
	logic        wrap_dn;
	logic [15:0] raw_delta;

	assign wrap_up   = (new_pos < zone.low_zone_limit) && (old_pos > zone.high_zone_limit);
	assign wrap_dn   = (new_pos > zone.high_zone_limit) && (old_pos < zone.low_zone_limit);
	assign raw_delta = new_pos - old_pos;

	always_comb begin
		result.position_delta = raw_delta;
		result.turn_count     = turns;
		// falling wrap wins on the delta; both together leave turns unchanged
		if (wrap_dn) begin
			result.position_delta = raw_delta - zone.counts_per_turn;
			result.turn_count     = wrap_up ? turns : turns - 16'd1;
		end else if (wrap_up) begin
			result.position_delta = raw_delta + zone.counts_per_turn;
			result.turn_count     = turns + 16'd1;
		end
	end

endmodule

// ===== rtl/core/modbus_encoder_turn_tracker.sv =====
// Top level: Modbus read-one-register reply tracker with multiturn unwrap.
//
// Input stream: one request per received serial byte or per poll event.
// s_tuser[0] is the mode (0 reply byte, 1 poll sent), s_tdata[7:0] the byte.
// A poll restarts collection of the 7-byte reply and bumps the timeout
// counter if the previous poll was never answered. The seventh byte checks
// station, function 3 and byte count 2, then updates position, previous
// values, delta and turn counter. CRC bytes are counted but not checked.
// Output stream: exactly one result request per input request, in order.
// A request passes through an input register, then the single-pass update
// into the output register, before m_tvalid rises. Throughput is one
// request per cycle while the receiver is ready; the state update in the
// second stage sets that figure.
// When the receiver stalls the output register holds, the input register
// fills and s_tready drops; nothing is lost or repeated.
// Configuration writes (cfg_index 0..3) are always ready and should be made
// while the stream is idle; other indexes are ignored.
// Reset (arst_n low) clears all counters, positions and the registers to
// their defaults; the header bytes and the output payload are left as they are.
module modbus_encoder_turn_tracker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,    // [7:0] rx_byte
	input  logic [0:0]   s_tuser,    // [0] mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,    // [0] frame_accepted, [16:1] position,
	                                 // [32:17] previous_position,
	                                 // [48:33] position_delta,
	                                 // [64:49] previous_delta, [80:65] turn_count,
	                                 // [96:81] timeout_errors, [97] awaiting_reply,
	                                 // [103:98] zero
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	logic [7:0]  station_q;
	mbet_pkg::zone_cfg_t zone_q;

	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;

	logic [7:0]  header_q [mbet_pkg::HeaderLen];
	logic [2:0]  count_q;
	logic        pending_q;
	logic [15:0] cur_pos_q;
	logic [15:0] old_pos_q;
	logic [15:0] cur_delta_q;
	logic [15:0] old_delta_q;
	logic [15:0] turns_q;
	logic [15:0] tally_q;

	logic        out_valid_q;
	logic [mbet_pkg::OutBits-1:0] out_data_q;

	logic        advance;
	logic        hdr_ok;
	logic        take;
	logic [15:0] new_pos;
	mbet_pkg::unwrap_t unw;

	logic        n_pending;
	logic [15:0] n_cur_pos;
	logic [15:0] n_old_pos;
	logic [15:0] n_cur_delta;
	logic [15:0] n_old_delta;
	logic [15:0] n_turns;
	logic [15:0] n_tally;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q              <= mbet_pkg::StationReset;
			zone_q.low_zone_limit  <= mbet_pkg::LowZoneReset;
			zone_q.high_zone_limit <= mbet_pkg::HighZoneReset;
			zone_q.counts_per_turn <= mbet_pkg::CptReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				mbet_pkg::RegStation:  station_q              <= cfg_data[7:0];
				mbet_pkg::RegLowZone:  zone_q.low_zone_limit  <= cfg_data;
				mbet_pkg::RegHighZone: zone_q.high_zone_limit <= cfg_data;
				mbet_pkg::RegCpt:      zone_q.counts_per_turn <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	assign hdr_ok  = (header_q[0] == station_q) && (header_q[1] == mbet_pkg::FuncRead)
	               && (header_q[2] == mbet_pkg::DataBytes);
	assign take    = !mode_s1 && (count_q == mbet_pkg::CountLast) && hdr_ok;
	assign new_pos = {header_q[3], header_q[4]};

	mbet_unwrap u_unwrap (
		.new_pos (new_pos),
		.old_pos (cur_pos_q),
		.turns   (turns_q),
		.zone    (zone_q),
		.result  (unw)
	);

	always_comb begin
		n_pending   = pending_q;
		n_cur_pos   = cur_pos_q;
		n_old_pos   = old_pos_q;
		n_cur_delta = cur_delta_q;
		n_old_delta = old_delta_q;
		n_turns     = turns_q;
		n_tally     = tally_q;
		if (mode_s1) begin
			n_pending = 1'b1;
			if (pending_q)
				n_tally = tally_q + 16'd1;
		end else if (take) begin
			n_pending   = 1'b0;
			n_old_pos   = cur_pos_q;
			n_cur_pos   = new_pos;
			n_old_delta = cur_delta_q;
			n_cur_delta = unw.position_delta;
			n_turns     = unw.turn_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pending_q   <= 1'b0;
			cur_pos_q   <= '0;
			old_pos_q   <= '0;
			cur_delta_q <= '0;
			old_delta_q <= '0;
			turns_q     <= '0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				if (mode_s1)
					count_q <= '0;
				else if (count_q != mbet_pkg::CountFull)
					count_q <= count_q + 3'd1;
				pending_q   <= n_pending;
				cur_pos_q   <= n_cur_pos;
				old_pos_q   <= n_old_pos;
				cur_delta_q <= n_cur_delta;
				old_delta_q <= n_old_delta;
				turns_q     <= n_turns;
				tally_q     <= n_tally;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// header bytes and output payload carry no reset
	always_ff @(posedge clk) begin
		if (advance && !mode_s1 && (count_q < mbet_pkg::CountHdrEnd))
			header_q[count_q] <= byte_s1;
		if (advance)
			out_data_q <= {6'd0, n_pending, n_tally, n_turns, n_old_delta, n_cur_delta,
			               n_old_pos, n_cur_pos, take};
	end

endmodule

// ===== bench/modbus_encoder_turn_tracker_tb.sv =====
// Self-checking bench for the Modbus reply tracker with multiturn encoder unwrap.
`timescale 1ns / 1ps

module modbus_encoder_turn_tracker_tb;

	localparam bit         ModeByte   = 1'b0;
	localparam bit         ModePoll   = 1'b1;
	localparam logic [7:0] RegUnused  = 8'hC5;
	localparam int         HoldCycles = 64;
	localparam int         IdleLimit  = 4000;
	localparam int         PhaseItems = 100;

	typedef struct {
		bit               accepted;
		bit [15:0]        position;
		bit [15:0]        prev_position;
		bit signed [15:0] delta;
		bit signed [15:0] prev_delta;
		bit signed [15:0] turns;
		bit [15:0]        timeouts;
		bit               awaiting;
	} tracker_result_t;

	class turn_tracker_board;
		bit [7:0]         station;
		bit [15:0]        low_lim;
		bit [15:0]        high_lim;
		bit [15:0]        turn_counts;
		bit [7:0]         header[mbet_pkg::HeaderLen];
		bit [2:0]         nbytes;
		bit               waiting;
		bit [15:0]        pos;
		bit [15:0]        prev_pos;
		bit [15:0]        timeouts;
		bit signed [15:0] delta;
		bit signed [15:0] prev_delta;
		bit signed [15:0] turns;
		tracker_result_t  expected_q[$];
		int               errors;

		function new();
			station = mbet_pkg::StationReset;
			low_lim = mbet_pkg::LowZoneReset;
			high_lim = mbet_pkg::HighZoneReset;
			turn_counts = mbet_pkg::CptReset;
			nbytes = 3'd0;
			waiting = 1'b0;
			pos = 16'd0;
			prev_pos = 16'd0;
			timeouts = 16'd0;
			delta = 16'sd0;
			prev_delta = 16'sd0;
			turns = 16'sd0;
			errors = 0;
		endfunction

		function void set_reg(logic [7:0] idx, logic [15:0] value);
			case (idx)
			mbet_pkg::RegStation: station = value[7:0];
			mbet_pkg::RegLowZone: low_lim = value;
			mbet_pkg::RegHighZone: high_lim = value;
			mbet_pkg::RegCpt: turn_counts = value;
			default: ;
			endcase
		endfunction

		// Runs one accepted request through the tracker and queues its result.
		function void note_request(bit mode, bit [7:0] rx);
			bit [15:0]       np;
			bit [15:0]       d;
			bit [15:0]       t;
			tracker_result_t r;
			r.accepted = 1'b0;
			if (mode == ModePoll) begin
				if (waiting)
					timeouts = timeouts + 16'd1;
				nbytes = 3'd0;
				waiting = 1'b1;
			end else if (nbytes < mbet_pkg::FrameLen) begin
				if (nbytes < mbet_pkg::HeaderLen)
					header[nbytes] = rx;
				nbytes = nbytes + 3'd1;
				if (nbytes == mbet_pkg::FrameLen && header[0] == station &&
						header[1] == mbet_pkg::FuncRead && header[2] == mbet_pkg::DataBytes) begin
					r.accepted = 1'b1;
					prev_pos = pos;
					np = {header[3], header[4]};
					prev_delta = delta;
					d = np - prev_pos;
					t = turns;
					if (np < low_lim && prev_pos > high_lim) begin
						d = np - prev_pos + turn_counts;
						t = t + 16'd1;
					end
					// applied after the forward wrap; both can hold when low > high
					if (np > high_lim && prev_pos < low_lim) begin
						d = np - prev_pos - turn_counts;
						t = t - 16'd1;
					end
					pos = np;
					delta = d;
					turns = t;
					waiting = 1'b0;
				end
			end
			r.position = pos;
			r.prev_position = prev_pos;
			r.delta = delta;
			r.prev_delta = prev_delta;
			r.turns = turns;
			r.timeouts = timeouts;
			r.awaiting = waiting;
			expected_q.push_back(r);
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			errors++;
			if (errors <= 40)
				$display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
		endtask

		task compare(string what, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report(what, got, want);
		endtask

		task check_result(logic [103:0] d);
			tracker_result_t w;
			if (expected_q.size() == 0) begin
				report("result with no request outstanding, position", d[16:1], 16'h0);
				return;
			end
			w = expected_q.pop_front();
			compare("frame_accepted", 16'(d[0]), 16'(w.accepted));
			compare("position", d[16:1], w.position);
			compare("previous_position", d[32:17], w.prev_position);
			compare("position_delta", d[48:33], w.delta);
			compare("previous_delta", d[64:49], w.prev_delta);
			compare("turn_count", d[80:65], w.turns);
			compare("timeout_errors", d[96:81], w.timeouts);
			compare("awaiting_reply", 16'(d[97]), 16'(w.awaiting));
			compare("pad bits", 16'(d[103:98]), 16'h0);
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic [0:0]   s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_index = 8'h00;
	logic [15:0]  cfg_data = 16'h0000;

	turn_tracker_board board = new();

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int requests_sent = 0;

	modbus_encoder_turn_tracker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off when asked for
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HoldCycles;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_request(bit mode, bit [7:0] rx);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= rx;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_request(mode, rx);
		requests_sent++;
	endtask

	task automatic send_frame(bit [7:0] st, bit [7:0] func, bit [7:0] cnt, bit [15:0] value,
			bit [15:0] crc);
		send_request(ModeByte, st);
		send_request(ModeByte, func);
		send_request(ModeByte, cnt);
		send_request(ModeByte, value[15:8]);
		send_request(ModeByte, value[7:0]);
		send_request(ModeByte, crc[7:0]);
		send_request(ModeByte, crc[15:8]);
	endtask

	// stop offering and wait until every result is back and the pipe is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(idx, value);
	endtask

	task automatic program_regs(int which);
		logic [7:0]  st;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] cpt;
		case (which)
		0: begin
			st = mbet_pkg::StationReset;
			lo = mbet_pkg::LowZoneReset;
			hi = mbet_pkg::HighZoneReset;
			cpt = mbet_pkg::CptReset;
		end
		1: begin st = 8'h00; lo = 16'h0000; hi = 16'hFFFF; cpt = 16'd1; end
		2: begin st = 8'hFF; lo = 16'hFFFF; hi = 16'h0000; cpt = 16'hFFFF; end
		default: begin
			st = 8'($urandom_range(255));
			lo = 16'($urandom_range(32767));
			hi = 16'($urandom_range(65535, lo));
			cpt = 16'($urandom_range(65535, 1));
		end
		endcase
		write_reg(mbet_pkg::RegStation, {8'h00, st});
		write_reg(mbet_pkg::RegLowZone, lo);
		write_reg(mbet_pkg::RegHighZone, hi);
		write_reg(mbet_pkg::RegCpt, cpt);
		write_reg(RegUnused, 16'($urandom_range(65535)));
		cfg_valid <= 1'b0;
	endtask

	// picks positions that land in the zones often enough to exercise the unwrap
	function automatic bit [15:0] pick_position();
		case ($urandom_range(3))
		0: return 16'($urandom_range(board.low_lim));
		1: return 16'($urandom_range(65535, board.high_lim));
		2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
		default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic send_sequence();
		int         kind;
		int         n;
		bit [7:0]   hdr[3];
		bit [15:0]  value;
		kind = $urandom_range(99);
		hdr[0] = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : board.station;
		hdr[1] = mbet_pkg::FuncRead;
		hdr[2] = mbet_pkg::DataBytes;
		value = pick_position();
		if (kind < 78) begin
			if (kind >= 70)
				hdr[2'($urandom_range(2))] ^= 8'($urandom_range(255, 1));
			send_request(ModePoll, 8'($urandom_range(255)));
			send_frame(hdr[0], hdr[1], hdr[2], value, 16'($urandom_range(65535)));
			if ($urandom_range(3) == 0)
				send_request(ModeByte, 8'($urandom_range(255)));
		end else if (kind < 85) begin
			send_request(ModePoll, 8'($urandom_range(255)));
		end else if (kind < 92) begin
			send_request(ModePoll, 8'($urandom_range(255)));
			n = $urandom_range(6, 1);
			repeat (n) send_request(ModeByte, 8'($urandom_range(255)));
		end else begin
			send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int ph;
		int phase_start;
		int saved_idle;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reply before any poll, forward wrap, ignored extra byte,
		// poll timeout, backward wrap
		send_frame(mbet_pkg::StationReset, mbet_pkg::FuncRead, mbet_pkg::DataBytes,
			16'h0C80, 16'h0000);
		send_request(ModePoll, 8'h00);
		send_frame(mbet_pkg::StationReset, mbet_pkg::FuncRead, mbet_pkg::DataBytes,
			16'h0010, 16'hFFFF);
		send_request(ModeByte, 8'hFF);
		send_request(ModePoll, 8'hFF);
		send_request(ModePoll, 8'h5A);
		send_frame(mbet_pkg::StationReset, mbet_pkg::FuncRead, mbet_pkg::DataBytes,
			16'h0F00, 16'hA55A);

		for (ph = 0; ph < 8; ph++) begin
			drain();
			program_regs(ph % 4);
			case ((ph + ph / 4) % 4)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 84; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 84; end
			default: begin idle_pct = 19; stall_pct = 19; end
			endcase
			phase_start = requests_sent;
			while (requests_sent - phase_start < PhaseItems / 2)
				send_sequence();
			if (ph == 2) begin
				// long receiver hold-off while requests keep coming
				hold_req <= hold_req + 1;
				saved_idle = idle_pct;
				idle_pct = 0;
				repeat (3) send_sequence();
				idle_pct = saved_idle;
			end
			if (ph == 5)
				drain();
			while (requests_sent - phase_start < PhaseItems)
				send_sequence();
		end

		drain();
		repeat (10) @(posedge clk);
		while (board.expected_q.size() != 0)
			board.report("result never arrived, position",
				16'h0, board.expected_q.pop_front().position);
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mbet_pkg.sv
rtl/core/mbet_unwrap.sv
rtl/core/modbus_encoder_turn_tracker.sv
bench/modbus_encoder_turn_tracker_tb.sv
